// File: rtl/ray_mesh_closest_hit_top_assert.svh
// Assertion macros for the ray mesh closest-hit block checker.
`ifndef RAY_MESH_CLOSEST_HIT_TOP_ASSERT_SVH
`define RAY_MESH_CLOSEST_HIT_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define RMCH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent, outside reset.
`define RMCH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rmch_pkg.sv
// Shared constants, types and helper functions of the ray mesh closest-hit block.
package rmch_pkg;

	localparam int MAX_TRIS  = 256;
	localparam int FRAC_BITS = 16;
	localparam int TRI_W     = $clog2(MAX_TRIS);
	localparam int CNT_W     = $clog2(MAX_TRIS + 1);
	localparam int IDX_W     = $clog2(3 * MAX_TRIS);
	localparam int PROD_W    = 64 - FRAC_BITS;
	localparam int ACC_W     = PROD_W + 3;
	localparam int INT_BITS  = 31 - FRAC_BITS;
	localparam int QB        = 31;
	localparam int NSTEPS    = 24;
	localparam int STEP_W    = $clog2(NSTEPS);

	localparam logic [1:0] CORNER_NONE = 2'd3;

	// operand vectors of the product sequencer
	localparam logic [2:0] V_DIR = 3'd0;
	localparam logic [2:0] V_E1  = 3'd1;
	localparam logic [2:0] V_E2  = 3'd2;
	localparam logic [2:0] V_D   = 3'd3;
	localparam logic [2:0] V_S1  = 3'd4;
	localparam logic [2:0] V_S2  = 3'd5;

	// destinations of a finished sum
	localparam logic [2:0] DST_S1  = 3'd0;
	localparam logic [2:0] DST_S2  = 3'd1;
	localparam logic [2:0] DST_DET = 3'd2;
	localparam logic [2:0] DST_N1  = 3'd3;
	localparam logic [2:0] DST_N2  = 3'd4;
	localparam logic [2:0] DST_NT  = 3'd5;

	typedef logic [2:0][31:0] vec_t;

	typedef struct packed {
		logic [2:0] av;
		logic [1:0] ac;
		logic [2:0] bv;
		logic [1:0] bc;
		logic       first;
		logic       neg;
		logic       last;
		logic [2:0] dst;
		logic [1:0] dc;
	} step_t;

	typedef struct packed {
		logic                    we;
		logic [IDX_W-1:0]        idx;
		logic [TRI_W-1:0]        slot;
		logic [7:0]              mat;
		vec_t                    pt;
	} wr_t;

	typedef struct packed {
		logic                    done;
		logic signed [ACC_W-1:0] det;
		logic signed [ACC_W-1:0] n1;
		logic signed [ACC_W-1:0] n2;
		logic signed [ACC_W-1:0] nt;
	} dots_t;

	typedef struct packed {
		logic              done;
		logic signed [31:0] t;
	} div_res_t;

	localparam logic signed [ACC_W-1:0] I32_MAX = {{(ACC_W-32){1'b0}}, 32'h7fffffff};
	localparam logic signed [ACC_W-1:0] I32_MIN = {{(ACC_W-32){1'b1}}, 32'h80000000};

	function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic [31:0] r;
		if (v > I32_MAX)
			r = 32'h7fffffff;
		else if (v < I32_MIN)
			r = 32'h80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic [31:0] sub_sat32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] d;
		logic [31:0] r;
		d = {a[31], a} - {b[31], b};
		if (d[32] != d[31])
			r = d[32] ? 32'h80000000 : 32'h7fffffff;
		else
			r = d[31:0];
		return r;
	endfunction

	function automatic vec_t vsub_sat(input vec_t a, input vec_t b);
		vec_t r;
		for (int i = 0; i < 3; i++)
			r[i] = sub_sat32(a[i], b[i]);
		return r;
	endfunction

	function automatic step_t mk(input logic [2:0] av, input logic [1:0] ac,
			input logic [2:0] bv, input logic [1:0] bc, input logic first,
			input logic neg, input logic last, input logic [2:0] dst,
			input logic [1:0] dc);
		step_t s;
		s.av = av; s.ac = ac; s.bv = bv; s.bc = bc;
		s.first = first; s.neg = neg; s.last = last; s.dst = dst; s.dc = dc;
		return s;
	endfunction

	// s1 = dir x e2, s2 = d x e1, then det, n1, n2, nt as dot products
	function automatic step_t step_rom(input logic [STEP_W-1:0] k);
		step_t s;
		unique case (k)
			5'd0:  s = mk(V_DIR, 2'd1, V_E2, 2'd2, 1'b1, 1'b0, 1'b0, DST_S1, 2'd0);
			5'd1:  s = mk(V_DIR, 2'd2, V_E2, 2'd1, 1'b0, 1'b1, 1'b1, DST_S1, 2'd0);
			5'd2:  s = mk(V_DIR, 2'd2, V_E2, 2'd0, 1'b1, 1'b0, 1'b0, DST_S1, 2'd1);
			5'd3:  s = mk(V_DIR, 2'd0, V_E2, 2'd2, 1'b0, 1'b1, 1'b1, DST_S1, 2'd1);
			5'd4:  s = mk(V_DIR, 2'd0, V_E2, 2'd1, 1'b1, 1'b0, 1'b0, DST_S1, 2'd2);
			5'd5:  s = mk(V_DIR, 2'd1, V_E2, 2'd0, 1'b0, 1'b1, 1'b1, DST_S1, 2'd2);
			5'd6:  s = mk(V_D,   2'd1, V_E1, 2'd2, 1'b1, 1'b0, 1'b0, DST_S2, 2'd0);
			5'd7:  s = mk(V_D,   2'd2, V_E1, 2'd1, 1'b0, 1'b1, 1'b1, DST_S2, 2'd0);
			5'd8:  s = mk(V_D,   2'd2, V_E1, 2'd0, 1'b1, 1'b0, 1'b0, DST_S2, 2'd1);
			5'd9:  s = mk(V_D,   2'd0, V_E1, 2'd2, 1'b0, 1'b1, 1'b1, DST_S2, 2'd1);
			5'd10: s = mk(V_D,   2'd0, V_E1, 2'd1, 1'b1, 1'b0, 1'b0, DST_S2, 2'd2);
			5'd11: s = mk(V_D,   2'd1, V_E1, 2'd0, 1'b0, 1'b1, 1'b1, DST_S2, 2'd2);
			5'd12: s = mk(V_S1,  2'd0, V_E1, 2'd0, 1'b1, 1'b0, 1'b0, DST_DET, 2'd0);
			5'd13: s = mk(V_S1,  2'd1, V_E1, 2'd1, 1'b0, 1'b0, 1'b0, DST_DET, 2'd0);
			5'd14: s = mk(V_S1,  2'd2, V_E1, 2'd2, 1'b0, 1'b0, 1'b1, DST_DET, 2'd0);
			5'd15: s = mk(V_D,   2'd0, V_S1, 2'd0, 1'b1, 1'b0, 1'b0, DST_N1, 2'd0);
			5'd16: s = mk(V_D,   2'd1, V_S1, 2'd1, 1'b0, 1'b0, 1'b0, DST_N1, 2'd0);
			5'd17: s = mk(V_D,   2'd2, V_S1, 2'd2, 1'b0, 1'b0, 1'b1, DST_N1, 2'd0);
			5'd18: s = mk(V_DIR, 2'd0, V_S2, 2'd0, 1'b1, 1'b0, 1'b0, DST_N2, 2'd0);
			5'd19: s = mk(V_DIR, 2'd1, V_S2, 2'd1, 1'b0, 1'b0, 1'b0, DST_N2, 2'd0);
			5'd20: s = mk(V_DIR, 2'd2, V_S2, 2'd2, 1'b0, 1'b0, 1'b1, DST_N2, 2'd0);
			5'd21: s = mk(V_E2,  2'd0, V_S2, 2'd0, 1'b1, 1'b0, 1'b0, DST_NT, 2'd0);
			5'd22: s = mk(V_E2,  2'd1, V_S2, 2'd1, 1'b0, 1'b0, 1'b0, DST_NT, 2'd0);
			5'd23: s = mk(V_E2,  2'd2, V_S2, 2'd2, 1'b0, 1'b0, 1'b1, DST_NT, 2'd0);
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

// File: rtl/rmch_store.sv
// Triangle corner memory and material memory, with registered reads.
module rmch_store (
	input  logic                       clk,
	input  rmch_pkg::wr_t              wr,
	input  logic [rmch_pkg::IDX_W-1:0] raddr,
	input  logic [rmch_pkg::TRI_W-1:0] mat_raddr,
	output rmch_pkg::vec_t             rdata,
	output logic [7:0]                 mat_rdata
);

	rmch_pkg::vec_t cmem [3*rmch_pkg::MAX_TRIS];
	logic [7:0]     mmem [rmch_pkg::MAX_TRIS];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			cmem[wr.idx]  <= wr.pt;
			mmem[wr.slot] <= wr.mat;
		end
		rdata     <= cmem[raddr];
		mat_rdata <= mmem[mat_raddr];
	end

endmodule

// File: rtl/rmch_mac.sv
// Shared multiplier and accumulator that forms the cross and dot products of one triangle.
module rmch_mac (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  rmch_pkg::vec_t  dir,
	input  rmch_pkg::vec_t  d,
	input  rmch_pkg::vec_t  e1,
	input  rmch_pkg::vec_t  e2,
	output rmch_pkg::dots_t res
);

	localparam int AW = rmch_pkg::ACC_W;
	localparam int PW = rmch_pkg::PROD_W;

	logic [rmch_pkg::STEP_W-1:0] step_q;
	logic                        run_q;
	logic                        vld_s1;
	rmch_pkg::step_t             ctl_s1;
	logic signed [PW-1:0]        prod_s1;
	logic signed [AW-1:0]        acc_q;
	rmch_pkg::vec_t              s1_q;
	rmch_pkg::vec_t              s2_q;
	logic signed [AW-1:0]        det_q, n1_q, n2_q, nt_q;
	logic                        done_q;

	rmch_pkg::step_t   st;
	rmch_pkg::vec_t    va, vb;
	logic signed [31:0] a, b;
	logic signed [63:0] prod;
	logic signed [AW-1:0] term, acc_n;

	function automatic rmch_pkg::vec_t pick(input logic [2:0] v, input rmch_pkg::vec_t dir_i,
			input rmch_pkg::vec_t e1_i, input rmch_pkg::vec_t e2_i, input rmch_pkg::vec_t d_i,
			input rmch_pkg::vec_t s1_i, input rmch_pkg::vec_t s2_i);
		rmch_pkg::vec_t r;
		unique case (v)
			rmch_pkg::V_DIR: r = dir_i;
			rmch_pkg::V_E1:  r = e1_i;
			rmch_pkg::V_E2:  r = e2_i;
			rmch_pkg::V_D:   r = d_i;
			rmch_pkg::V_S1:  r = s1_i;
			rmch_pkg::V_S2:  r = s2_i;
			default:         r = '0;
		endcase
		return r;
	endfunction

	always_comb begin
		st   = rmch_pkg::step_rom(step_q);
		va   = pick(st.av, dir, e1, e2, d, s1_q, s2_q);
		vb   = pick(st.bv, dir, e1, e2, d, s1_q, s2_q);
		a    = (st.ac == 2'd3) ? 32'sd0 : $signed(va[st.ac[1:0]]);
		b    = (st.bc == 2'd3) ? 32'sd0 : $signed(vb[st.bc[1:0]]);
		prod = a * b;
		// floor rounding of the Q product is the arithmetic shift
		term  = AW'(prod_s1);
		if (ctl_s1.neg)
			term = -term;
		acc_n = ctl_s1.first ? term : acc_q + term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			run_q  <= 1'b0;
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= run_q;
			done_q <= vld_s1 && ctl_s1.last && (ctl_s1.dst == rmch_pkg::DST_NT);
			if (start) begin
				step_q <= '0;
				run_q  <= 1'b1;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == rmch_pkg::STEP_W'(rmch_pkg::NSTEPS - 1))
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod[63:rmch_pkg::FRAC_BITS];
		ctl_s1  <= st;
		if (vld_s1) begin
			acc_q <= acc_n;
			if (ctl_s1.last) begin
				unique case (ctl_s1.dst)
					rmch_pkg::DST_S1:  s1_q[ctl_s1.dc] <= rmch_pkg::sat32(acc_n);
					rmch_pkg::DST_S2:  s2_q[ctl_s1.dc] <= rmch_pkg::sat32(acc_n);
					rmch_pkg::DST_DET: det_q <= acc_n;
					rmch_pkg::DST_N1:  n1_q  <= acc_n;
					rmch_pkg::DST_N2:  n2_q  <= acc_n;
					rmch_pkg::DST_NT:  nt_q  <= acc_n;
					default: ;
				endcase
			end
		end
	end

	assign res.done = done_q;
	assign res.det  = det_q;
	assign res.n1   = n1_q;
	assign res.n2   = n2_q;
	assign res.nt   = nt_q;

endmodule

// File: rtl/rmch_div.sv
// Restoring divider, one quotient bit per cycle, giving the saturated Q16.16 hit distance.
module rmch_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       neg,
	input  logic [rmch_pkg::ACC_W-1:0] num,
	input  logic [rmch_pkg::ACC_W-1:0] den,
	output rmch_pkg::div_res_t         res
);

	localparam int AW    = rmch_pkg::ACC_W;
	localparam int EXT_W = AW + rmch_pkg::INT_BITS;
	localparam int REM_W = AW + rmch_pkg::FRAC_BITS;
	localparam int DSH_W = AW + rmch_pkg::QB - 1;
	localparam int CW    = $clog2(rmch_pkg::QB);

	logic [REM_W-1:0]          rem_q;
	logic [DSH_W-1:0]          dsh_q;
	logic [rmch_pkg::QB-1:0]   quo_q;
	logic [CW-1:0]             cnt_q;
	logic                      run_q;
	logic                      neg_q;
	logic                      done_q;
	logic signed [31:0]        t_q;

	logic       ge;
	logic       over;
	logic [31:0] qfull;

	always_comb begin
		over = EXT_W'(num) >= (EXT_W'(den) << rmch_pkg::INT_BITS);
		ge   = DSH_W'(rem_q) >= dsh_q;
		qfull = {1'b0, quo_q[rmch_pkg::QB-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= !over;
				done_q <= over;
			end else if (run_q && cnt_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= REM_W'(num) << rmch_pkg::FRAC_BITS;
			dsh_q <= DSH_W'(den) << (rmch_pkg::QB - 1);
			quo_q <= '0;
			cnt_q <= CW'(rmch_pkg::QB - 1);
			neg_q <= neg;
			t_q   <= neg ? 32'sh80000000 : 32'sh7fffffff;
		end else if (run_q) begin
			if (ge)
				rem_q <= rem_q - dsh_q[REM_W-1:0];
			dsh_q <= dsh_q >> 1;
			quo_q <= qfull[rmch_pkg::QB-1:0];
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0)
				t_q <= neg_q ? -$signed(qfull) : $signed(qfull);
		end
	end

	assign res.done = done_q;
	assign res.t    = t_q;

endmodule

// File: rtl/ray_mesh_closest_hit_top.sv
// Ray mesh closest-hit top level: command port, triangle sequencer and nearest-hit tracking.
//
// A load item (req_type 0) writes one triangle corner (none for corner 3) in the item's own
// cycle and leaves busy low. A ray item (req_type 1) raises busy and walks triangles
// 0 .. tri_count-1 (at most 256), one at a time: three corner reads from the corner memory,
// edge set-up, 24 products through one shared 32x32 multiplier, the accept test, the
// bit-serial divider for the distance (skipped when rejected), and the nearest-hit update.
// The result comes with done high for exactly one cycle and must be taken then; the receiver
// cannot stall it.
module ray_mesh_closest_hit_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               req_type,
	input  logic [7:0]         tri_slot,
	input  logic [1:0]         corner,
	input  logic [7:0]         material_in,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	input  logic signed [31:0] ray_t_min,
	input  logic signed [31:0] ray_t_max,
	output logic               done,
	output logic               hit,
	output logic [7:0]         hit_material,
	output logic signed [31:0] hit_distance,
	output logic [7:0]         hit_triangle,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int AW = rmch_pkg::ACC_W;
	localparam int CW = rmch_pkg::CNT_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_SUB  = 3'd2;
	localparam logic [2:0] ST_MAC  = 3'd3;
	localparam logic [2:0] ST_CHK  = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_CMP  = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	logic [2:0]         state_q;
	logic [CW-1:0]      tri_count_q;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      tri_q;
	logic [1:0]         rd_cnt_q;
	rmch_pkg::vec_t     org_q, dir_q;
	logic signed [31:0] tmin_q, tmax_q;
	rmch_pkg::vec_t     p_q [3];
	logic [7:0]         mat_q;
	rmch_pkg::vec_t     e1_q, e2_q, d_q;
	logic signed [31:0] t_q;
	logic               any_q;
	logic signed [31:0] best_t_q;
	logic [7:0]         best_m_q;
	logic [7:0]         best_i_q;
	logic               done_q;
	logic               hit_q;
	logic [7:0]         hit_mat_q;
	logic [31:0]        hit_dist_q;
	logic [7:0]         hit_tri_q;

	rmch_pkg::wr_t      wr;
	logic [rmch_pkg::IDX_W-1:0] raddr;
	rmch_pkg::vec_t     rdata;
	logic [7:0]         mat_rdata;
	rmch_pkg::dots_t    dots;
	rmch_pkg::div_res_t dres;

	logic               accept;
	logic               cfg_wr;
	logic               last_tri;
	logic signed [AW-1:0] det_a, n1_a, n2_a, nt_a;
	logic signed [AW:0]   n12;
	logic               reject;
	logic               in_range;

	assign accept = start && !busy;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign busy   = state_q != ST_IDLE;
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {{(32-CW){1'b0}}, tri_count_q};

	always_comb begin
		wr.we   = accept && !req_type && corner != rmch_pkg::CORNER_NONE;
		wr.idx  = rmch_pkg::IDX_W'({tri_slot, 1'b0}) + rmch_pkg::IDX_W'(tri_slot)
			+ rmch_pkg::IDX_W'(corner);
		wr.slot = tri_slot;
		wr.mat  = material_in;
		wr.pt   = {point_z, point_y, point_x};
		raddr   = rmch_pkg::IDX_W'({tri_q[rmch_pkg::TRI_W-1:0], 1'b0})
			+ rmch_pkg::IDX_W'(tri_q[rmch_pkg::TRI_W-1:0]) + rmch_pkg::IDX_W'(rd_cnt_q);
	end

	rmch_store u_store (
		.clk       (clk),
		.wr        (wr),
		.raddr     (raddr),
		.mat_raddr (tri_q[rmch_pkg::TRI_W-1:0]),
		.rdata     (rdata),
		.mat_rdata (mat_rdata)
	);

	rmch_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_SUB),
		.dir    (dir_q),
		.d      (d_q),
		.e1     (e1_q),
		.e2     (e2_q),
		.res    (dots)
	);

	// back-facing triangles: flip all signs so the tests read det > 0
	always_comb begin
		det_a = dots.det[AW-1] ? -dots.det : dots.det;
		n1_a  = dots.det[AW-1] ? -dots.n1  : dots.n1;
		n2_a  = dots.det[AW-1] ? -dots.n2  : dots.n2;
		nt_a  = dots.det[AW-1] ? -dots.nt  : dots.nt;
		n12   = {n1_a[AW-1], n1_a} + {n2_a[AW-1], n2_a};
		reject = (dots.det == '0) || n1_a[AW-1] || (n1_a > det_a) || n2_a[AW-1]
			|| (n12 > {det_a[AW-1], det_a});
		in_range = (t_q >= tmin_q) && (t_q <= tmax_q);
		last_tri = (tri_q + 1'b1) == n_q;
	end

	rmch_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_CHK && !reject),
		.neg    (nt_a[AW-1]),
		.num    (nt_a[AW-1] ? -nt_a : nt_a),
		.den    (det_a),
		.res    (dres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tri_count_q <= '0;
			tri_q       <= '0;
			rd_cnt_q    <= '0;
			any_q       <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr && !paddr[2])
				tri_count_q <= pwdata[CW-1:0];
			unique case (state_q)
				ST_IDLE: begin
					if (accept && req_type) begin
						tri_q    <= '0;
						rd_cnt_q <= '0;
						any_q    <= 1'b0;
						state_q  <= (tri_count_q == '0) ? ST_DONE : ST_RD;
					end
				end
				ST_RD: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == 2'd3)
						state_q <= ST_SUB;
				end
				ST_SUB:  state_q <= ST_MAC;
				ST_MAC:  if (dots.done) state_q <= ST_CHK;
				ST_CHK: begin
					if (!reject)
						state_q <= ST_DIV;
					else if (last_tri)
						state_q <= ST_DONE;
					else begin
						tri_q    <= tri_q + 1'b1;
						rd_cnt_q <= '0;
						state_q  <= ST_RD;
					end
				end
				ST_DIV:  if (dres.done) state_q <= ST_CMP;
				ST_CMP: begin
					if (in_range && (!any_q || t_q < best_t_q))
						any_q <= 1'b1;
					if (last_tri)
						state_q <= ST_DONE;
					else begin
						tri_q    <= tri_q + 1'b1;
						rd_cnt_q <= '0;
						state_q  <= ST_RD;
					end
				end
				ST_DONE: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req_type) begin
			org_q  <= {point_z, point_y, point_x};
			dir_q  <= {dir_z, dir_y, dir_x};
			tmin_q <= ray_t_min;
			tmax_q <= ray_t_max;
			n_q    <= (tri_count_q > CW'(rmch_pkg::MAX_TRIS)) ?
				CW'(rmch_pkg::MAX_TRIS) : tri_count_q;
		end
		if (state_q == ST_RD && rd_cnt_q != 2'd0)
			p_q[rd_cnt_q - 2'd1] <= rdata;
		if (state_q == ST_RD && rd_cnt_q == 2'd1)
			mat_q <= mat_rdata;
		if (state_q == ST_SUB) begin
			e1_q <= rmch_pkg::vsub_sat(p_q[1], p_q[0]);
			e2_q <= rmch_pkg::vsub_sat(p_q[2], p_q[0]);
			d_q  <= rmch_pkg::vsub_sat(org_q, p_q[0]);
		end
		if (state_q == ST_DIV && dres.done)
			t_q <= dres.t;
		if (state_q == ST_CMP && in_range && (!any_q || t_q < best_t_q)) begin
			best_t_q <= t_q;
			best_m_q <= mat_q;
			best_i_q <= tri_q[7:0];
		end
		if (state_q == ST_DONE) begin
			hit_q      <= any_q;
			hit_mat_q  <= any_q ? best_m_q : 8'd0;
			hit_dist_q <= any_q ? best_t_q : 32'd0;
			hit_tri_q  <= any_q ? best_i_q : 8'd0;
		end
	end

	assign done         = done_q;
	assign hit          = hit_q;
	assign hit_material = hit_mat_q;
	assign hit_distance = hit_dist_q;
	assign hit_triangle = hit_tri_q;

endmodule

// File: rtl/rmch_chk.sv
// Port-level checker for the ray mesh closest-hit block and its bind.
`include "ray_mesh_closest_hit_top_assert.svh"

module rmch_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               req_type,
	input logic               done,
	input logic               hit,
	input logic [7:0]         hit_material,
	input logic signed [31:0] hit_distance,
	input logic [7:0]         hit_triangle
);

	`RMCH_ASSERT_NEXT(a_done_single, done, !done, "done held longer than one cycle")
	`RMCH_ASSERT(a_done_busy, done |-> $past(busy), "result without a ray in flight")
	`RMCH_ASSERT(a_miss_zero, (done && !hit) |-> (hit_material == 8'd0 && hit_distance == 32'sd0 && hit_triangle == 8'd0), "miss result carries data")
	`RMCH_ASSERT_NEXT(a_load_free, (start && !busy && !req_type), (!busy && !done), "load item occupied the block")
	`RMCH_ASSERT_NEXT(a_ray_busy, (start && !busy && req_type), busy, "ray item not taken")

endmodule

bind ray_mesh_closest_hit_top rmch_chk u_rmch_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.req_type     (req_type),
	.done         (done),
	.hit          (hit),
	.hit_material (hit_material),
	.hit_distance (hit_distance),
	.hit_triangle (hit_triangle)
);
